@@ design/bcfd_pkg.sv @@
// bcfd_pkg: shared constants for the BMS CAN frame decoder.
// No dependencies; imported by the CRC unit and the top level.

package bcfd_pkg;

    // Item kinds (input cmd and result kind share the encoding)
    localparam logic CmdFrame = 1'b0;
    localparam logic CmdTick  = 1'b1;

    // Known receive identifiers
    localparam logic [10:0] IdMsg1 = 11'h41A;  // voltage, current, cell min/max, heartbeat
    localparam logic [10:0] IdMsg3 = 11'h41C;  // charge limit, fault code
    localparam logic [10:0] IdMsg4 = 11'h41D;  // state of charge

    // Current offset, 0.1 A units
    localparam logic [16:0] CurrentOffset = 17'd5000;

    // CRC-32 as computed by the MCU peripheral: MSB first, no reflection, no final xor
    localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;
    localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

    // Payload bytes 0..6 feed the check, byte 7 carries it
    localparam int unsigned CrcDataW = 56;

endpackage

@@ design/bcfd_stream_if.sv @@
// bcfd_stream_if: valid/ready channels for the BMS CAN frame decoder.
// bcfd_in_if carries one frame or tick; bcfd_out_if carries one result.

interface bcfd_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [10:0] frame_id;
    logic [63:0] payload;
    logic [7:0]  vehicle_state;
    logic [7:0]  force_shutdown;
    logic [7:0]  connect_hv;

    modport source (
        output valid, cmd, frame_id, payload, vehicle_state, force_shutdown, connect_hv,
        input  ready
    );
    modport sink (
        input  valid, cmd, frame_id, payload, vehicle_state, force_shutdown, connect_hv,
        output ready
    );
endinterface

interface bcfd_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic               frame_accepted;
    logic               timed_out;
    logic               data_valid;
    logic [7:0]         fault_code;
    logic [15:0]        pack_voltage_raw;
    logic signed [16:0] pack_current_raw;
    logic [7:0]         cell_v_min_raw;
    logic [7:0]         cell_v_max_raw;
    logic [15:0]        soc_raw;
    logic [15:0]        charge_limit_raw;
    logic [63:0]        tx_frame;

    modport source (
        output valid, kind, frame_accepted, timed_out, data_valid, fault_code,
               pack_voltage_raw, pack_current_raw, cell_v_min_raw, cell_v_max_raw,
               soc_raw, charge_limit_raw, tx_frame,
        input  ready
    );
    modport sink (
        input  valid, kind, frame_accepted, timed_out, data_valid, fault_code,
               pack_voltage_raw, pack_current_raw, cell_v_min_raw, cell_v_max_raw,
               soc_raw, charge_limit_raw, tx_frame,
        output ready
    );
endinterface

@@ design/bcfd_crc.sv @@
// bcfd_crc: combinational CRC-32 over seven data bytes, fed as two little-endian words.
// Depends on bcfd_pkg for the polynomial, seed and data width.

module bcfd_crc import bcfd_pkg::*; (
    input  logic [CrcDataW-1:0] i_data,
    output logic [31:0]         o_crc
);

    // One 32-bit word, MSB first; flattens into an XOR network
    function automatic logic [31:0] f_crc_word(input logic [31:0] crc_in,
                                               input logic [31:0] word);
        logic [31:0] c;
        c = crc_in ^ word;
        for (int i = 0; i < 32; i++) begin
            if (c[31]) begin
                c = {c[30:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

    logic [31:0] w_word0;
    logic [31:0] w_word1;
    logic [31:0] w_crc0;

    // Word 0 is bytes 0..3, word 1 is bytes 4..6 with the top byte zero
    assign w_word0 = i_data[31:0];
    assign w_word1 = {{(64 - CrcDataW){1'b0}}, i_data[CrcDataW-1:32]};

    assign w_crc0 = f_crc_word(CrcInit, w_word0);
    assign o_crc  = f_crc_word(w_crc0, w_word1);

endmodule

@@ design/bms_can_frame_decoder_unit.sv @@
// BMS CAN frame decoder. Each transaction on i_frm is either a received CAN frame or a
// 100 ms tick, and yields exactly one transaction on o_res, in order. The block takes one
// item per clock while o_res is not stalled. The accepting edge loads the input register;
// the CRC check, field unpack and state update then run in one pass into the result
// register, which loads once it is free or drained.
// The combinational CRC-32 network sets the critical path. Stored telemetry and the timeout
// counter clear on reset, so the block reports timed out until the first good 0x41A frame.
// TIMEOUT_TICKS is the counter reload value (1 to 65535 ticks).

module bms_can_frame_decoder_unit import bcfd_pkg::*; #(
    parameter int TIMEOUT_TICKS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcfd_in_if.sink     i_frm,
    bcfd_out_if.source  o_res
);

    localparam logic [15:0] TmoReload = 16'(TIMEOUT_TICKS);

    // Input stage
    logic        r_in_vld;
    logic        r_cmd;
    logic [10:0] r_id;
    logic [63:0] r_pl;
    logic [7:0]  r_veh;
    logic [7:0]  r_fsd;
    logic [7:0]  r_chv;

    // Decoder state
    logic [15:0]        r_tmo,  n_tmo;
    logic [3:0]         r_seq,  n_seq;
    logic [15:0]        r_volt, n_volt;
    logic signed [16:0] r_curr, n_curr;
    logic [7:0]         r_cmin, n_cmin;
    logic [7:0]         r_cmax, n_cmax;
    logic [15:0]        r_soc,  n_soc;
    logic [15:0]        r_chg,  n_chg;
    logic [7:0]         r_flt,  n_flt;

    // Result register
    logic        r_out_vld;
    logic        r_res_kind;
    logic        r_res_acc;
    logic        r_res_tmo;
    logic        r_res_dv;
    logic [63:0] r_res_tx;

    logic                w_adv;
    logic                w_known;
    logic                w_accept;
    logic                w_tmo;
    logic [63:0]         w_tx;
    logic [CrcDataW-1:0] w_crc_data;
    logic [31:0]         w_crc;

    // Pipeline handshake: compute stage moves when the result register is free or drained
    assign w_adv       = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_frm.ready = !r_in_vld || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_frm.ready) begin
            r_in_vld <= i_frm.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frm.valid && i_frm.ready) begin
            r_cmd <= i_frm.cmd;
            r_id  <= i_frm.frame_id;
            r_pl  <= i_frm.payload;
            r_veh <= i_frm.vehicle_state;
            r_fsd <= i_frm.force_shutdown;
            r_chv <= i_frm.connect_hv;
        end
    end

    // Shared CRC: received bytes 0..6 for a frame, status bytes for a tick
    assign w_crc_data = (r_cmd == CmdTick) ? {28'd0, r_seq, r_chv, r_fsd, r_veh}
                                           : r_pl[CrcDataW-1:0];

    bcfd_crc u_crc (
        .i_data (w_crc_data),
        .o_crc  (w_crc)
    );

    assign w_known = r_id inside {IdMsg1, IdMsg3, IdMsg4};

    // Next state and result
    always_comb begin
        n_tmo    = r_tmo;
        n_seq    = r_seq;
        n_volt   = r_volt;
        n_curr   = r_curr;
        n_cmin   = r_cmin;
        n_cmax   = r_cmax;
        n_soc    = r_soc;
        n_chg    = r_chg;
        n_flt    = r_flt;
        w_accept = 1'b0;
        w_tx     = '0;
        if (r_cmd == CmdFrame) begin
            if (w_known && (w_crc[7:0] == r_pl[63:56])) begin
                w_accept = 1'b1;
                unique case (r_id)
                    IdMsg1: begin
                        n_volt = r_pl[15:0];
                        n_curr = $signed({1'b0, r_pl[31:16]} - CurrentOffset);
                        n_cmin = r_pl[39:32];
                        n_cmax = r_pl[47:40];
                        n_tmo  = TmoReload;
                    end
                    IdMsg3: begin
                        n_chg = r_pl[31:16];
                        n_flt = r_pl[47:40];
                    end
                    default: begin
                        n_soc = r_pl[15:0];
                    end
                endcase
            end
        end else begin
            if (r_tmo != 16'd0) begin
                n_tmo = r_tmo - 16'd1;
            end
            w_tx  = {w_crc[7:0], 28'd0, r_seq, r_chv, r_fsd, r_veh};
            n_seq = r_seq + 4'd1;
        end
    end

    assign w_tmo = (n_tmo == 16'd0);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tmo  <= '0;
            r_seq  <= '0;
            r_volt <= '0;
            r_curr <= '0;
            r_cmin <= '0;
            r_cmax <= '0;
            r_soc  <= '0;
            r_chg  <= '0;
            r_flt  <= '0;
        end else if (w_adv) begin
            r_tmo  <= n_tmo;
            r_seq  <= n_seq;
            r_volt <= n_volt;
            r_curr <= n_curr;
            r_cmin <= n_cmin;
            r_cmax <= n_cmax;
            r_soc  <= n_soc;
            r_chg  <= n_chg;
            r_flt  <= n_flt;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res_kind <= r_cmd;
            r_res_acc  <= w_accept;
            r_res_tmo  <= w_tmo;
            r_res_dv   <= !w_tmo && (n_flt == 8'd0);
            r_res_tx   <= w_tx;
        end
    end

    // Telemetry fields read straight from the state, which always matches the latest result
    assign o_res.valid            = r_out_vld;
    assign o_res.kind             = r_res_kind;
    assign o_res.frame_accepted   = r_res_acc;
    assign o_res.timed_out        = r_res_tmo;
    assign o_res.data_valid       = r_res_dv;
    assign o_res.fault_code       = r_flt;
    assign o_res.pack_voltage_raw = r_volt;
    assign o_res.pack_current_raw = r_curr;
    assign o_res.cell_v_min_raw   = r_cmin;
    assign o_res.cell_v_max_raw   = r_cmax;
    assign o_res.soc_raw          = r_soc;
    assign o_res.charge_limit_raw = r_chg;
    assign o_res.tx_frame         = r_res_tx;

    // Assertions
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_cmd == CmdTick) |=> (r_seq == $past(r_seq) + 4'd1))
        else $error("sequence number did not advance on tick");

    a_heartbeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_accept && r_id == IdMsg1) |=> (r_tmo == TmoReload))
        else $error("accepted 0x41A frame did not reload timeout counter");

    a_frame_no_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res_kind == CmdFrame) |-> (r_res_tx == 64'd0))
        else $error("frame result carries a status frame");

    a_valid_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res_dv) |-> (!r_res_tmo && r_flt == 8'd0))
        else $error("data_valid set while timed out or faulted");

    a_tick_no_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_cmd == CmdTick) |=> !r_res_acc)
        else $error("tick result flagged as accepted frame");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// testbench: checks bms_can_frame_decoder_unit, one frame or tick in, one result out.
// Depends on bcfd_pkg, the bcfd_in_if / bcfd_out_if interfaces and the decoder top level.

module testbench;
    import bcfd_pkg::*;

    localparam int TIMEOUT_TICKS   = 10;
    localparam int RANDOM_ITEMS    = 550;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 100;

    typedef struct packed {
        logic        cmd;
        logic [10:0] frame_id;
        logic [63:0] payload;
        logic [7:0]  vehicle_state;
        logic [7:0]  force_shutdown;
        logic [7:0]  connect_hv;
    } frame_item_t;

    typedef struct packed {
        logic        kind;
        logic        frame_accepted;
        logic        timed_out;
        logic        data_valid;
        logic [7:0]  fault_code;
        logic [15:0] pack_voltage_raw;
        logic [16:0] pack_current_raw;
        logic [7:0]  cell_v_min_raw;
        logic [7:0]  cell_v_max_raw;
        logic [15:0] soc_raw;
        logic [15:0] charge_limit_raw;
        logic [63:0] tx_frame;
    } decoder_result_t;

    // CRC-32, MSB first, over bytes 0..3 then bytes 4..6 (byte 7 zeroed); low byte kept
    function automatic logic [7:0] crc_check_byte(logic [63:0] bytes);
        logic [31:0] crc;
        logic [31:0] words [2];
        words[0] = bytes[31:0];
        words[1] = {8'h00, bytes[55:32]};
        crc = CrcInit;
        for (int w = 0; w < 2; w++) begin
            crc ^= words[w];
            for (int b = 0; b < 32; b++)
                crc = crc[31] ? ((crc << 1) ^ CrcPoly) : (crc << 1);
        end
        return crc[7:0];
    endfunction

    // Telemetry predictor plus the queue of results still owed by the block
    class decoder_scoreboard;
        logic [15:0]     heartbeat_left;
        logic [3:0]      tx_seq;
        logic [15:0]     voltage;
        logic [16:0]     current;
        logic [7:0]      cell_min;
        logic [7:0]      cell_max;
        logic [15:0]     soc;
        logic [15:0]     charge_limit;
        logic [7:0]      fault;
        decoder_result_t expected_q[$];
        int unsigned     mismatches;

        function new();
            heartbeat_left = '0;
            tx_seq         = '0;
            voltage        = '0;
            current        = '0;
            cell_min       = '0;
            cell_max       = '0;
            soc            = '0;
            charge_limit   = '0;
            fault          = '0;
            mismatches     = 0;
        endfunction

        function void note_item(frame_item_t it);
            decoder_result_t r;
            logic known;
            r = '0;
            r.kind = it.cmd;
            if (it.cmd == CmdFrame) begin
                known = (it.frame_id == IdMsg1) || (it.frame_id == IdMsg3) ||
                        (it.frame_id == IdMsg4);
                if (known && crc_check_byte(it.payload) == it.payload[63:56]) begin
                    r.frame_accepted = 1'b1;
                    if (it.frame_id == IdMsg1) begin
                        voltage        = it.payload[15:0];
                        current        = {1'b0, it.payload[31:16]} - CurrentOffset;
                        cell_min       = it.payload[39:32];
                        cell_max       = it.payload[47:40];
                        heartbeat_left = 16'(TIMEOUT_TICKS);
                    end else if (it.frame_id == IdMsg3) begin
                        charge_limit = it.payload[31:16];
                        fault        = it.payload[47:40];
                    end else begin
                        soc = it.payload[15:0];
                    end
                end
            end else begin
                // tick: counter saturates at zero, status frame carries its own check byte
                if (heartbeat_left != 0)
                    heartbeat_left--;
                r.tx_frame = {32'h0, 4'h0, tx_seq, it.connect_hv, it.force_shutdown,
                              it.vehicle_state};
                r.tx_frame[63:56] = crc_check_byte(r.tx_frame);
                tx_seq++;
            end
            r.timed_out        = (heartbeat_left == 0);
            r.data_valid       = !r.timed_out && (fault == 0);
            r.fault_code       = fault;
            r.pack_voltage_raw = voltage;
            r.pack_current_raw = current;
            r.cell_v_min_raw   = cell_min;
            r.cell_v_max_raw   = cell_max;
            r.soc_raw          = soc;
            r.charge_limit_raw = charge_limit;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
            if (want !== seen) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
            end
        endfunction

        function void check_result(decoder_result_t got);
            decoder_result_t e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("result transaction with nothing outstanding");
                return;
            end
            e = expected_q.pop_front();
            compare_field("kind",             e.kind,             got.kind);
            compare_field("frame_accepted",   e.frame_accepted,   got.frame_accepted);
            compare_field("timed_out",        e.timed_out,        got.timed_out);
            compare_field("data_valid",       e.data_valid,       got.data_valid);
            compare_field("fault_code",       e.fault_code,       got.fault_code);
            compare_field("pack_voltage_raw", e.pack_voltage_raw, got.pack_voltage_raw);
            compare_field("pack_current_raw", e.pack_current_raw, got.pack_current_raw);
            compare_field("cell_v_min_raw",   e.cell_v_min_raw,   got.cell_v_min_raw);
            compare_field("cell_v_max_raw",   e.cell_v_max_raw,   got.cell_v_max_raw);
            compare_field("soc_raw",          e.soc_raw,          got.soc_raw);
            compare_field("charge_limit_raw", e.charge_limit_raw, got.charge_limit_raw);
            compare_field("tx_frame",         e.tx_frame,         got.tx_frame);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;

    decoder_scoreboard sb = new();

    bcfd_in_if  frm_bus ();
    bcfd_out_if res_bus ();

    bms_can_frame_decoder_unit #(
        .TIMEOUT_TICKS(TIMEOUT_TICKS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_frm  (frm_bus),
        .o_res  (res_bus)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand_payload();
        return {$urandom, $urandom};
    endfunction

    // Frame with byte 7 set to the right check byte, or corrupted when good_crc is low
    function automatic frame_item_t make_frame(logic [10:0] id, logic [63:0] body,
                                               bit good_crc);
        frame_item_t it;
        it.cmd            = CmdFrame;
        it.frame_id       = id;
        it.payload        = body;
        it.vehicle_state  = 8'($urandom_range(0, 255));
        it.force_shutdown = 8'($urandom_range(0, 255));
        it.connect_hv     = 8'($urandom_range(0, 255));
        it.payload[63:56] = crc_check_byte(body);
        if (!good_crc)
            it.payload[63:56] ^= 8'($urandom_range(1, 255));
        return it;
    endfunction

    // Tick; id and payload are don't-care and get noise
    function automatic frame_item_t make_tick(logic [7:0] vs, logic [7:0] fs, logic [7:0] hv);
        frame_item_t it;
        it.cmd            = CmdTick;
        it.frame_id       = 11'($urandom_range(0, 2047));
        it.payload        = rand_payload();
        it.vehicle_state  = vs;
        it.force_shutdown = fs;
        it.connect_hv     = hv;
        return it;
    endfunction

    // Mostly good frames on known ids; heartbeat_on gates 0x41A so timeouts happen
    function automatic frame_item_t random_item(bit heartbeat_on);
        int unsigned pick;
        logic [10:0] id;
        logic [63:0] body;
        pick = $urandom_range(0, 99);
        body = rand_payload();
        case ($urandom_range(heartbeat_on ? 0 : 1, 2))
            0:       id = IdMsg1;
            1:       id = IdMsg3;
            default: id = IdMsg4;
        endcase
        if (id == IdMsg3 && $urandom_range(0, 1) == 1)
            body[47:40] = 8'h00;
        if (pick < 30)
            return make_tick(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
        else if (pick < 82)
            return make_frame(id, body, 1'b1);
        else if (pick < 90)
            return make_frame(id, body, 1'b0);
        return make_frame(11'($urandom_range(0, 2047)), body, $urandom_range(0, 1) == 1);
    endfunction

    // Drive one transaction; returns at the edge where it is taken.
    // Handshake is sampled at the falling edge, where everything is settled.
    task automatic send_item(frame_item_t it);
        bit taken;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            frm_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        frm_bus.valid          <= 1'b1;
        frm_bus.cmd            <= it.cmd;
        frm_bus.frame_id       <= it.frame_id;
        frm_bus.payload        <= it.payload;
        frm_bus.vehicle_state  <= it.vehicle_state;
        frm_bus.force_shutdown <= it.force_shutdown;
        frm_bus.connect_hv     <= it.connect_hv;
        do begin
            @(negedge i_clk);
            taken = frm_bus.ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic run_directed();
        // ticks while still timed out after reset, byte extremes
        send_item(make_tick(8'h00, 8'h00, 8'h00));
        send_item(make_tick(8'hFF, 8'hFF, 8'hFF));
        // heartbeat frame, current at both ends of its range, then 0x41C and 0x41D frames
        send_item(make_frame(IdMsg1, 64'h0, 1'b1));
        send_item(make_frame(IdMsg1, 64'h00FF_FFFF_FFFF_FFFF, 1'b1));
        send_item(make_frame(IdMsg3, 64'h0000_00FF_FFFF_FFFF, 1'b1));
        send_item(make_frame(IdMsg4, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
        // check byte mismatch leaves the state alone
        send_item(make_frame(IdMsg4, 64'h0000_0000_0000_1234, 1'b0));
        send_item(make_frame(IdMsg3, 64'h0000_5A00_0000_0000, 1'b0));
        // unknown identifiers with a valid check byte
        send_item(make_frame(11'h000, 64'h0012_3456_789A_BCDE, 1'b1));
        send_item(make_frame(11'h7FF, 64'h00FF_FFFF_FFFF_FFFF, 1'b1));
        send_item(make_frame(11'h41B, 64'h0000_0000_0000_0042, 1'b1));
        send_item(make_frame(11'h437, 64'h0000_0000_0000_0042, 1'b1));
        // nonzero fault code drops data_valid, then cleared again
        send_item(make_frame(IdMsg3, 64'h0000_8000_1234_0000, 1'b1));
        send_item(make_frame(IdMsg3, 64'h0000_0000_0100_0000, 1'b1));
        // heartbeat loss: count down to zero and one more tick past it
        for (int k = 0; k < 11; k++)
            send_item(make_tick(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255))));
    endtask

    // Result side stalls at random
    initial begin : result_sink
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Transaction monitor and watchdog on cycles with no transaction on either side
    initial begin : monitor
        int unsigned     quiet_cycles;
        frame_item_t     seen;
        decoder_result_t got;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_CYCLES) begin
            @(negedge i_clk);
            quiet_cycles++;
            if (i_rst_n && frm_bus.valid && frm_bus.ready) begin
                seen.cmd            = frm_bus.cmd;
                seen.frame_id       = frm_bus.frame_id;
                seen.payload        = frm_bus.payload;
                seen.vehicle_state  = frm_bus.vehicle_state;
                seen.force_shutdown = frm_bus.force_shutdown;
                seen.connect_hv     = frm_bus.connect_hv;
                sb.note_item(seen);
                quiet_cycles = 0;
            end
            if (i_rst_n && res_bus.valid && res_bus.ready) begin
                got.kind             = res_bus.kind;
                got.frame_accepted   = res_bus.frame_accepted;
                got.timed_out        = res_bus.timed_out;
                got.data_valid       = res_bus.data_valid;
                got.fault_code       = res_bus.fault_code;
                got.pack_voltage_raw = res_bus.pack_voltage_raw;
                got.pack_current_raw = res_bus.pack_current_raw;
                got.cell_v_min_raw   = res_bus.cell_v_min_raw;
                got.cell_v_max_raw   = res_bus.cell_v_max_raw;
                got.soc_raw          = res_bus.soc_raw;
                got.charge_limit_raw = res_bus.charge_limit_raw;
                got.tx_frame         = res_bus.tx_frame;
                sb.check_result(got);
                quiet_cycles = 0;
            end
        end
        $display("bms_can_frame_decoder_unit test failed");
        $finish;
    end

    // Reset, directed items, then three random phases with different idling
    initial begin : stimulus
        bit heartbeat_on;
        src_idle_pct = 34;
        snk_idle_pct = 88;
        heartbeat_on = 1'b1;
        i_rst_n                <= 1'b0;
        frm_bus.valid          <= 1'b0;
        frm_bus.cmd            <= CmdFrame;
        frm_bus.frame_id       <= '0;
        frm_bus.payload        <= '0;
        frm_bus.vehicle_state  <= '0;
        frm_bus.force_shutdown <= '0;
        frm_bus.connect_hv     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 88 : 0;
            snk_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 34 : 0;
            for (int n = 0; n < (RANDOM_ITEMS + 2) / 3; n++) begin
                if (n % 40 == 0)
                    heartbeat_on = ($urandom_range(0, 2) != 0);
                send_item(random_item(heartbeat_on));
            end
        end
        frm_bus.valid <= 1'b0;

        // drain, then give the pipeline time to show any stray result
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("bms_can_frame_decoder_unit test passed");
        else
            $display("bms_can_frame_decoder_unit test failed");
        $finish;
    end

endmodule
